@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files of the project.
// Needs no other file; every macro samples on the rising edge of the given clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/u8dec_pkg.sv @@
// Shared constants and types for the UTF-8 stream decoder.
// Has no dependencies; the decoder's RTL files (not the assertion macros or the checker) use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package u8dec_pkg;

    localparam int ByteW = 8;
    localparam int CpW   = 31;
    localparam int LenW  = 3;

    // Byte class masks and the tags that identify each class.
    localparam logic [ByteW-1:0] MASK_CONT = 8'hC0;
    localparam logic [ByteW-1:0] TAG_CONT  = 8'h80;
    localparam logic [ByteW-1:0] MASK_LEAD2 = 8'hE0;
    localparam logic [ByteW-1:0] TAG_LEAD2  = 8'hC0;
    localparam logic [ByteW-1:0] MASK_LEAD3 = 8'hF0;
    localparam logic [ByteW-1:0] TAG_LEAD3  = 8'hE0;
    localparam logic [ByteW-1:0] MASK_LEAD4 = 8'hF8;
    localparam logic [ByteW-1:0] TAG_LEAD4  = 8'hF0;
    localparam logic [ByteW-1:0] MASK_LEAD5 = 8'hFC;
    localparam logic [ByteW-1:0] TAG_LEAD5  = 8'hF8;
    localparam logic [ByteW-1:0] MASK_LEAD6 = 8'hFE;
    localparam logic [ByteW-1:0] TAG_LEAD6  = 8'hFC;

    // Payload bit masks for continuation and lead bytes.
    localparam logic [ByteW-1:0] PAY_CONT  = 8'h3F;
    localparam logic [ByteW-1:0] PAY_LEAD2 = 8'h1F;
    localparam logic [ByteW-1:0] PAY_LEAD3 = 8'h0F;
    localparam logic [ByteW-1:0] PAY_LEAD4 = 8'h07;
    localparam logic [ByteW-1:0] PAY_LEAD5 = 8'h03;
    localparam logic [ByteW-1:0] PAY_LEAD6 = 8'h01;

    typedef enum logic {
        ERR_BAD_LEAD     = 1'b0,
        ERR_MISSING_CONT = 1'b1
    } t_err_kind;

    typedef struct packed {
        logic [CpW-1:0]  code_point;
        logic [LenW-1:0] seq_length;
        logic            error;
        t_err_kind       error_kind;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/utf8_stream_decoder.sv @@
// Top level of the UTF-8 stream decoder (six-byte form, 31-bit code points).
// Depends on u8dec_pkg, u8dec_in_stage, u8dec_decode and u8dec_out_buf.
//
//   Channel | Direction | Handshake              | Payload
//   in      | input     | i_in_valid / o_in_stall | i_data_byte
//   out     | output    | o_out_valid / i_out_stall | o_code_point, o_seq_length,
//           |           |                        | o_error, o_error_kind
//
// One byte is accepted per clock cycle, sustained, while the output side keeps up.
// The byte that completes a result waits in the input register, and the result is then
// registered in the result register (first in the skid entry while the output stalls).
// Reset is synchronous and active low; it empties both registers and returns
// the decoder to the idle state between sequences.
// When the output stalls, one further result is caught in a skid entry; once it is
// full, the input register holds its byte and o_in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Byte channel.
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [u8dec_pkg::ByteW-1:0]  i_data_byte,
    // Result channel.
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [u8dec_pkg::CpW-1:0]         o_code_point,
    output logic [u8dec_pkg::LenW-1:0]        o_seq_length,
    output logic                              o_error,
    output logic                              o_error_kind
);

    logic                        w_byte_valid;
    logic [u8dec_pkg::ByteW-1:0] w_byte;
    logic                        w_buf_ready;
    logic                        w_take;
    logic                        w_push;
    u8dec_pkg::t_result          w_result;
    u8dec_pkg::t_result          w_out_result;

    // The decode stage moves a byte on whenever the result buffer has room, whether
    // or not that byte produces a result; the sequence state advances only then.
    assign w_take = w_byte_valid && w_buf_ready;

    u8dec_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_take      (w_take),
        .o_valid     (w_byte_valid),
        .o_byte      (w_byte)
    );

    u8dec_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_byte   (w_byte),
        .o_push   (w_push),
        .o_result (w_result)
    );

    u8dec_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_result    (w_result),
        .o_ready     (w_buf_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (w_out_result)
    );

    // The result travels as one record and is split onto its ports here.
    assign o_code_point = w_out_result.code_point;
    assign o_seq_length = w_out_result.seq_length;
    assign o_error      = w_out_result.error;
    assign o_error_kind = w_out_result.error_kind;

endmodule

`default_nettype wire

@@ rtl/u8dec_in_stage.sv @@
// Input register of the UTF-8 stream decoder: holds one byte until the decode stage takes it.
// Depends on u8dec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8dec_in_stage (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [u8dec_pkg::ByteW-1:0] i_data_byte,
    input  wire logic                        i_take,
    output logic                             o_valid,
    output logic [u8dec_pkg::ByteW-1:0]      o_byte
);

    logic                        r_valid;
    logic [u8dec_pkg::ByteW-1:0] r_byte;
    logic                        w_load;

    // The register may be refilled in the same cycle as its byte moves on.
    assign o_in_stall = r_valid && !i_take;
    assign w_load     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_load || (r_valid && !i_take);
        end
        if (w_load) begin
            r_byte <= i_data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

@@ rtl/u8dec_decode.sv @@
// Decode stage: classifies one byte, updates the sequence state and forms the result.
// Depends on u8dec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8dec_decode (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_take,
    input  wire logic [u8dec_pkg::ByteW-1:0] i_byte,
    output logic                             o_push,
    output u8dec_pkg::t_result               o_result
);

    logic [u8dec_pkg::LenW-1:0] r_remaining, n_remaining;
    logic [u8dec_pkg::CpW-1:0]  r_acc, n_acc;
    logic [u8dec_pkg::LenW-1:0] r_length, n_length;
    logic [u8dec_pkg::CpW-1:0]  w_acc_shift;
    logic                       w_emit;

    assign w_acc_shift = {r_acc[u8dec_pkg::CpW-7:0], i_byte[5:0]};

    always_comb begin
        n_remaining         = r_remaining;
        n_acc               = r_acc;
        n_length            = r_length;
        w_emit              = 1'b0;
        o_result.code_point = '0;
        o_result.seq_length = '0;
        o_result.error      = 1'b0;
        o_result.error_kind = u8dec_pkg::ERR_BAD_LEAD;

        if (r_remaining != '0) begin
            if ((i_byte & u8dec_pkg::MASK_CONT) != u8dec_pkg::TAG_CONT) begin
                // Sequence broken: drop it together with the offending byte.
                n_remaining         = '0;
                n_acc               = '0;
                n_length            = '0;
                w_emit              = 1'b1;
                o_result.error      = 1'b1;
                o_result.error_kind = u8dec_pkg::ERR_MISSING_CONT;
            end else if (r_remaining == 3'd1) begin
                n_remaining         = '0;
                n_acc               = '0;
                n_length            = '0;
                w_emit              = 1'b1;
                o_result.code_point = w_acc_shift;
                o_result.seq_length = r_length;
            end else begin
                n_remaining = r_remaining - 3'd1;
                n_acc       = w_acc_shift;
            end
        end else begin
            priority if (!i_byte[7]) begin
                w_emit              = 1'b1;
                o_result.code_point = u8dec_pkg::CpW'(i_byte);
                o_result.seq_length = 3'd1;
            end else if ((i_byte & u8dec_pkg::MASK_LEAD2) == u8dec_pkg::TAG_LEAD2) begin
                n_acc       = u8dec_pkg::CpW'(i_byte & u8dec_pkg::PAY_LEAD2);
                n_remaining = 3'd1;
                n_length    = 3'd2;
            end else if ((i_byte & u8dec_pkg::MASK_LEAD3) == u8dec_pkg::TAG_LEAD3) begin
                n_acc       = u8dec_pkg::CpW'(i_byte & u8dec_pkg::PAY_LEAD3);
                n_remaining = 3'd2;
                n_length    = 3'd3;
            end else if ((i_byte & u8dec_pkg::MASK_LEAD4) == u8dec_pkg::TAG_LEAD4) begin
                n_acc       = u8dec_pkg::CpW'(i_byte & u8dec_pkg::PAY_LEAD4);
                n_remaining = 3'd3;
                n_length    = 3'd4;
            end else if ((i_byte & u8dec_pkg::MASK_LEAD5) == u8dec_pkg::TAG_LEAD5) begin
                n_acc       = u8dec_pkg::CpW'(i_byte & u8dec_pkg::PAY_LEAD5);
                n_remaining = 3'd4;
                n_length    = 3'd5;
            end else if ((i_byte & u8dec_pkg::MASK_LEAD6) == u8dec_pkg::TAG_LEAD6) begin
                n_acc       = u8dec_pkg::CpW'(i_byte & u8dec_pkg::PAY_LEAD6);
                n_remaining = 3'd5;
                n_length    = 3'd6;
            end else begin
                // Stray continuation byte, or 0xFE / 0xFF.
                w_emit              = 1'b1;
                o_result.error      = 1'b1;
                o_result.error_kind = u8dec_pkg::ERR_BAD_LEAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_acc       <= '0;
            r_length    <= '0;
        end else if (i_take) begin
            r_remaining <= n_remaining;
            r_acc       <= n_acc;
            r_length    <= n_length;
        end
    end

    assign o_push = i_take && w_emit;

endmodule

`default_nettype wire

@@ rtl/u8dec_out_buf.sv @@
// Result register with one skid entry, so the ready towards the decode stage is registered.
// Depends on u8dec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8dec_out_buf (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire u8dec_pkg::t_result  i_result,
    output logic                     o_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output u8dec_pkg::t_result       o_result
);

    logic               r_main_valid;
    logic               r_skid_valid;
    u8dec_pkg::t_result r_main;
    u8dec_pkg::t_result r_skid;
    logic               w_pop;

    assign w_pop   = r_main_valid && !i_out_stall;
    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // No push can arrive while the skid entry is full.
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_main_valid && !w_pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (r_main_valid && !w_pop) begin
                r_skid <= i_result;
            end else begin
                r_main <= i_result;
            end
        end
    end

    assign o_out_valid = r_main_valid;
    assign o_result    = r_main;

endmodule

`default_nettype wire

@@ rtl/u8dec_checker.sv @@
// Port-level checks on the result channel of the UTF-8 stream decoder, bound to the top level.
// Depends on assert_macros.svh and utf8_stream_decoder.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module u8dec_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [30:0] o_code_point,
    input wire logic [2:0]  o_seq_length,
    input wire logic        o_error,
    input wire logic        o_error_kind
);

    `ASSERT_IMPLIES(a_error_zero_payload, i_clk, i_rst_n, o_out_valid && o_error, (o_code_point == 31'd0) && (o_seq_length == 3'd0), "error result carries a payload")

    `ASSERT_IMPLIES(a_good_result_length, i_clk, i_rst_n, o_out_valid && !o_error, (o_seq_length != 3'd0) && (o_seq_length != 3'd7) && !o_error_kind, "good result has a bad length or error kind")

    `ASSERT_IMPLIES(a_short_seq_range, i_clk, i_rst_n, o_out_valid && (o_seq_length == 3'd1 || o_seq_length == 3'd2), (o_code_point[30:11] == 20'd0) && (o_seq_length != 3'd1 || o_code_point[10:7] == 4'd0), "code point too wide for its sequence length")

    `ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_code_point) && $stable(o_seq_length) && $stable(o_error) && $stable(o_error_kind), "stalled result changed")

endmodule

bind utf8_stream_decoder u8dec_checker u_u8dec_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_code_point (o_code_point),
    .o_seq_length (o_seq_length),
    .o_error      (o_error),
    .o_error_kind (o_error_kind)
);

`default_nettype wire
